>>> rtl/scancode_to_keycode_buffer_macros.svh
// Assertion helpers for the keycode buffer.
`ifndef SCANCODE_TO_KEYCODE_BUFFER_MACROS_SVH
`define SCANCODE_TO_KEYCODE_BUFFER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SKB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SKB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/skb_pkg.sv
`default_nettype none
package skb_pkg;
  localparam int BufEntries = 16;
  localparam int IdxW = $clog2(BufEntries);

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [2:0] {
    FN_SCAN  = 3'd0,
    FN_READ  = 3'd1,
    FN_PEEK  = 3'd2,
    FN_STORE = 3'd3,
    FN_SHIFT = 3'd4,
    FN_EXT   = 3'd5,
    FN_RSVD6 = 3'd6,
    FN_RSVD7 = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_BREAK  = 3'd1,
    EV_SYSRQ  = 3'd2,
    EV_SYSRQR = 3'd3,
    EV_PRTSC  = 3'd4,
    EV_RESET  = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  scancode;
    logic        extended_mode;
    logic [15:0] key_value;
  } req_t;

  typedef struct packed {
    logic [15:0] key_code;
    logic        buffer_empty;
    logic        store_failed;
    logic [15:0] flags_out;
    logic [2:0]  event_res;
  } rsp_t;

  // ring write command from control to memory
  typedef struct packed {
    logic        we;
    idx_t        addr;
    logic [15:0] data;
  } ring_wr_t;

  localparam int RomRows = 89;

  function automatic logic [47:0] rom_row(input logic [6:0] sc);
    logic [47:0] r;
    r = '0;
    case (sc)
      7'h01: r = {16'h011b, 16'h011b, 16'h011b};
      7'h02: r = {16'h0000, 16'h02b0, 16'h0231};
      7'h03: r = {16'h0300, 16'h03a7, 16'h0332};
      7'h04: r = {16'h0000, 16'h0000, 16'h0433};
      7'h05: r = {16'h0000, 16'h05bb, 16'h0534};
      7'h06: r = {16'h0000, 16'h06ab, 16'h0635};
      7'h07: r = {16'h071e, 16'h0724, 16'h0736};
      7'h08: r = {16'h0000, 16'h0880, 16'h0837};
      7'h09: r = {16'h0000, 16'h0000, 16'h0938};
      7'h0a: r = {16'h0000, 16'h0000, 16'h0a39};
      7'h0b: r = {16'h0000, 16'h0000, 16'h0b30};
      7'h0c: r = {16'h0c1f, 16'h0c2d, 16'h0c2d};
      7'h0e: r = {16'h0e7f, 16'h0e08, 16'h0e08};
      7'h0f: r = {16'h9400, 16'h0f00, 16'h0f09};
      7'h10: r = {16'h0000, 16'h1058, 16'h1078};
      7'h11: r = {16'h115f, 16'h1156, 16'h1176};
      7'h12: r = {16'h125b, 16'h124c, 16'h126c};
      7'h13: r = {16'h135d, 16'h1343, 16'h1363};
      7'h14: r = {16'h145e, 16'h1457, 16'h1477};
      7'h15: r = {16'h1521, 16'h154b, 16'h156b};
      7'h16: r = {16'h163c, 16'h1648, 16'h1668};
      7'h17: r = {16'h173e, 16'h1747, 16'h1767};
      7'h18: r = {16'h183d, 16'h1846, 16'h1866};
      7'h19: r = {16'h1926, 16'h1951, 16'h1971};
      7'h1a: r = {16'h0000, 16'h0000, 16'h1adf};
      7'h1c: r = {16'h1c0a, 16'h1c0d, 16'h1c0d};
      7'h1e: r = {16'h1e5c, 16'h1e55, 16'h1e75};
      7'h1f: r = {16'h1f2f, 16'h1f49, 16'h1f69};
      7'h20: r = {16'h207b, 16'h2041, 16'h2061};
      7'h21: r = {16'h217d, 16'h2145, 16'h2165};
      7'h22: r = {16'h222a, 16'h224f, 16'h226f};
      7'h23: r = {16'h233f, 16'h2353, 16'h2373};
      7'h24: r = {16'h2428, 16'h244e, 16'h246e};
      7'h25: r = {16'h2529, 16'h2552, 16'h2572};
      7'h26: r = {16'h262d, 16'h2654, 16'h2674};
      7'h27: r = {16'h273a, 16'h2744, 16'h2764};
      7'h28: r = {16'h2840, 16'h2859, 16'h2879};
      7'h2c: r = {16'h2c23, 16'h2cdc, 16'h2cfc};
      7'h2d: r = {16'h2d24, 16'h2dd6, 16'h2df6};
      7'h2e: r = {16'h2e7c, 16'h2ec4, 16'h2ee4};
      7'h2f: r = {16'h2f7e, 16'h2f50, 16'h2f70};
      7'h30: r = {16'h3060, 16'h305a, 16'h307a};
      7'h31: r = {16'h312b, 16'h3142, 16'h3162};
      7'h32: r = {16'h3225, 16'h324d, 16'h326d};
      7'h33: r = {16'h3322, 16'h0000, 16'h332c};
      7'h34: r = {16'h3427, 16'h0000, 16'h342e};
      7'h35: r = {16'h353b, 16'h354a, 16'h356a};
      7'h37: r = {16'h9600, 16'h372a, 16'h372a};
      7'h39: r = {16'h3920, 16'h3920, 16'h3920};
      7'h3b: r = {16'h5e00, 16'h5400, 16'h3b00};
      7'h3c: r = {16'h5f00, 16'h5500, 16'h3c00};
      7'h3d: r = {16'h6000, 16'h5600, 16'h3d00};
      7'h3e: r = {16'h6100, 16'h5700, 16'h3e00};
      7'h3f: r = {16'h6200, 16'h5800, 16'h3f00};
      7'h40: r = {16'h6300, 16'h5900, 16'h4000};
      7'h41: r = {16'h6400, 16'h5a00, 16'h4100};
      7'h42: r = {16'h6500, 16'h5b00, 16'h4200};
      7'h43: r = {16'h6600, 16'h5c00, 16'h4300};
      7'h44: r = {16'h6700, 16'h5d00, 16'h4400};
      7'h47: r = {16'h7700, 16'h4737, 16'h4700};
      7'h48: r = {16'h8d00, 16'h4838, 16'h4800};
      7'h49: r = {16'h8400, 16'h4939, 16'h4900};
      7'h4a: r = {16'h8e00, 16'h4a2d, 16'h4a2d};
      7'h4b: r = {16'h7300, 16'h4b34, 16'h4b00};
      7'h4c: r = {16'h8f00, 16'h4c35, 16'h4c00};
      7'h4d: r = {16'h7400, 16'h4d36, 16'h4d00};
      7'h4e: r = {16'h9000, 16'h4e2b, 16'h4e2b};
      7'h4f: r = {16'h7500, 16'h4f31, 16'h4f00};
      7'h50: r = {16'h9100, 16'h5032, 16'h5000};
      7'h51: r = {16'h7600, 16'h5133, 16'h5100};
      7'h52: r = {16'h9200, 16'h5230, 16'h5200};
      7'h53: r = {16'h9300, 16'h532e, 16'h5300};
      7'h56: r = {16'h0000, 16'h567c, 16'h565c};
      7'h57: r = {16'h8900, 16'h8700, 16'h8500};
      7'h58: r = {16'h8a00, 16'h8800, 16'h8600};
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/skb_if.sv
`default_nettype none
interface skb_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/scancode_to_keycode_buffer.sv
`default_nettype none
// Set-1 scancode translator with a 16-entry keycode ring. Every request
// (scancode, read, peek, store, flag query) gives exactly one result item.
// An item passes through these steps: the cycle in which it is
// accepted, an execute cycle in which the registered ring read of the head
// slot returns and the state is updated (ROM lookup and ring write happen
// here), and an output phase in which the result register is offered
// until taken. The input is ready again in the cycle after the result is
// taken, so a new item is not accepted before the last result is taken.
// One item is in flight at a time; the ring memory's registered read sets
// the execute step.
module scancode_to_keycode_buffer (
  input  wire logic clk,
  input  wire logic rst_n,
  skb_if.sink       in_ch,
  skb_if.source     out_ch
);
  import skb_pkg::*;

  ring_wr_t    ring_wr;
  idx_t        ring_rd_addr;
  logic [15:0] ring_rd_data;
  idx_t        head, tail;

  // ring storage
  skb_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd_data)
  );

  // request sequencer and flag state
  skb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_ch.valid),
    .req_ready    (in_ch.ready),
    .req          (in_ch.data),
    .rsp_valid    (out_ch.valid),
    .rsp_ready    (out_ch.ready),
    .rsp          (out_ch.data),
    .ring_wr      (ring_wr),
    .ring_rd_addr (ring_rd_addr),
    .ring_rd_data (ring_rd_data),
    .head_o       (head),
    .tail_o       (tail)
  );

`include "scancode_to_keycode_buffer_macros.svh"
  // only one item in flight
  `SKB_ASSERT_IMP(a_no_overlap, out_ch.valid, !in_ch.ready, "accept while result pending")
  // a failed store leaves the ring full
  `SKB_ASSERT_IMP(a_fail_full, out_ch.valid && out_ch.data.store_failed,
    (tail + idx_t'(1)) == head, "store failed with room in ring")
  // empty report means head equals tail
  `SKB_ASSERT_IMP(a_empty, out_ch.valid && out_ch.data.buffer_empty, head == tail,
    "empty reported on non-empty ring")
endmodule
`default_nettype wire

>>> rtl/skb_ring.sv
`default_nettype none
// Keycode ring storage: one write port, one registered read port.
module skb_ring (
  input  wire logic            clk,
  input  wire skb_pkg::ring_wr_t wr,
  input  wire skb_pkg::idx_t   rd_addr,
  output logic [15:0]          rd_data
);
  import skb_pkg::*;
  logic [15:0] mem [BufEntries];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

>>> rtl/skb_ctrl.sv
`default_nettype none
// Request sequencer: registers the request, reads the ring head, updates state.
module skb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire skb_pkg::req_t   req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output skb_pkg::rsp_t        rsp,
  output skb_pkg::ring_wr_t    ring_wr,
  output skb_pkg::idx_t        ring_rd_addr,
  input  wire logic [15:0]     ring_rd_data,
  output skb_pkg::idx_t        head_o,
  output skb_pkg::idx_t        tail_o
);
  import skb_pkg::*;

  state_t      state_r, state_nxt;
  req_t        req_r;
  rsp_t        rsp_r, rsp_nxt;
  idx_t        head_r, head_nxt, tail_r, tail_nxt;
  logic [15:0] sf_r, sf_nxt;
  logic [4:0]  xf_r, xf_nxt;
  logic [1:0]  layer_r, layer_nxt;
  ring_wr_t    wr_nxt;

  assign ring_rd_addr = head_r;
  assign head_o = head_r;
  assign tail_o = tail_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (req_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_OUT;
      ST_OUT:  if (rsp_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state_r == ST_IDLE);
    rsp_valid = (state_r == ST_OUT);
    rsp       = rsp_r;
  end

  // execute stage: the ring's registered head read is valid in ST_EXEC
  always_comb begin
    logic        rel, e0, e1, stop, push, nots, full;
    logic [6:0]  sc;
    logic [47:0] row;
    logic [15:0] kc, rk;
    logic [7:0]  lo;
    logic [1:0]  lay;
    idx_t        tn;
    sf_nxt = sf_r; xf_nxt = xf_r; layer_nxt = layer_r;
    head_nxt = head_r; tail_nxt = tail_r;
    rsp_nxt = '0;
    wr_nxt = '0;
    rel = req_r.scancode[7];
    sc = req_r.scancode[6:0];
    e0 = xf_r[1];
    e1 = xf_r[0];
    stop = 1'b0; push = 1'b0; kc = '0; nots = 1'b0; lay = '0; row = '0;
    tn = tail_r + idx_t'(1);
    full = (tn == head_r);
    rk = ring_rd_data; lo = rk[7:0];
    case (func_t'(req_r.func))
      FN_SCAN: begin
        if (req_r.scancode == 8'he0 || req_r.scancode == 8'he1) begin
          xf_nxt = xf_r | (req_r.scancode == 8'he0 ? 5'h02 : 5'h01);
        end else if (e1 && sc == 7'h1d) begin
          xf_nxt = xf_r;
        end else begin
          xf_nxt = xf_r & ~5'h03;
          stop = 1'b1;
          case (sc)
            7'h3a, 7'h2b: layer_nxt = rel ? (layer_r & 2'b01) : (layer_r | 2'b10);
            7'h2a: if (!e0) sf_nxt = rel ? (sf_r & ~16'h0002) : (sf_r | 16'h0002);
            7'h36: if (!e0) sf_nxt = rel ? (sf_r & ~16'h0001) : (sf_r | 16'h0001);
            7'h1d: begin
              if (e0) begin
                sf_nxt = rel ? (sf_r & ~16'h0004) : (sf_r | 16'h0004);
                xf_nxt = rel ? (xf_nxt & ~5'h04) : (xf_nxt | 5'h04);
              end else begin
                sf_nxt = rel ? (sf_r & ~16'h0104) : (sf_r | 16'h0104);
              end
            end
            7'h38: begin
              if (e0) begin
                sf_nxt = rel ? (sf_r & ~16'h0008) : (sf_r | 16'h0008);
                xf_nxt = rel ? (xf_nxt & ~5'h08) : (xf_nxt | 5'h08);
              end else begin
                sf_nxt = rel ? (sf_r & ~16'h0208) : (sf_r | 16'h0208);
              end
            end
            7'h45: if (!e1) sf_nxt = rel ? (sf_r & ~16'h2000) : ((sf_r ^ 16'h0020) | 16'h2000);
            7'h46: begin
              if (e0) begin
                if (rel) begin
                  // ctrl-break: flush ring, leave a zero key in slot 0
                  head_nxt = '0;
                  tail_nxt = idx_t'(1);
                  wr_nxt = '{we: 1'b1, addr: '0, data: 16'h0000};
                  rsp_nxt.event_res = EV_BREAK;
                end
              end else begin
                sf_nxt = rel ? (sf_r & ~16'h1000) : ((sf_r ^ 16'h0010) | 16'h1000);
              end
            end
            7'h37: if (e0) begin
              if (!rel) rsp_nxt.event_res = EV_PRTSC;
            end else stop = 1'b0;
            7'h54: rsp_nxt.event_res = rel ? EV_SYSRQR : EV_SYSRQ;
            7'h53: if (!rel && sf_r[2] && sf_r[3]) rsp_nxt.event_res = EV_RESET;
                   else stop = 1'b0;
            default: stop = 1'b0;
          endcase
          if (!stop && !rel && sc != 7'h00 && sc < 7'(RomRows)) begin
            row = rom_row(sc);
            if (e0 && sc == 7'h1c) row = {16'he00a, 16'he00d, 16'he00d};
            if (e0 && sc == 7'h35) row = {16'h9500, 16'he02f, 16'he02f};
            nots = !(sf_r[0] || sf_r[1]);
            if ((sf_r[5] && sc >= 7'h47 && sc <= 7'h53) ||
                (sf_r[6] && row[7:0] >= 8'h61 && row[7:0] <= 8'h7a)) begin
              nots = !nots;
            end
            lay = nots ? (layer_r & 2'b10) : (layer_r | 2'b01);
            layer_nxt = lay;
            case (lay)
              2'd0: kc = row[15:0];
              2'd1: kc = row[31:16];
              2'd2: kc = row[47:32];
              default: kc = '0;
            endcase
            if (e0 && sc >= 7'h47 && sc <= 7'h53) begin
              kc = sf_r[3] ? {8'(sc) + 8'h50, 8'h00} : {kc[15:8], 8'he0};
            end
            push = (kc != 16'h0000);
          end
        end
      end
      FN_READ, FN_PEEK: begin
        if (head_r == tail_r) begin
          rsp_nxt.buffer_empty = 1'b1;
        end else begin
          if (!req_r.extended_mode) begin
            if (lo == 8'he0 && rk[15:8] != 8'h00) rk = {rk[15:8], 8'h00};
            else if (rk == 16'he00d || rk == 16'he00a) rk = {8'h1c, lo};
            else if (rk == 16'he02f) rk = 16'h352f;
          end
          if (lo == 8'hf0 && rk[15:8] != 8'h00) rk = {rk[15:8], 8'h00};
          rsp_nxt.key_code = rk;
          if (func_t'(req_r.func) == FN_READ) head_nxt = head_r + idx_t'(1);
        end
      end
      FN_STORE: begin
        push = 1'b1;
        kc = req_r.key_value;
      end
      FN_SHIFT: rsp_nxt.flags_out = {8'h00, sf_r[7:0]};
      FN_EXT:   rsp_nxt.flags_out = {sf_r[15:12], xf_r[3:2], sf_r[9:0]};
      default: ;
    endcase
    if (push) begin
      if (full) begin
        rsp_nxt.store_failed = 1'b1;
      end else begin
        wr_nxt = '{we: 1'b1, addr: tail_r, data: kc};
        tail_nxt = tn;
      end
    end
  end

  assign ring_wr = (state_r == ST_EXEC) ? wr_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      sf_r    <= '0;
      xf_r    <= 5'h10;
      layer_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EXEC) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        sf_r    <= sf_nxt;
        xf_r    <= xf_nxt;
        layer_r <= layer_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && req_valid) req_r <= req;
    if (state_r == ST_EXEC) rsp_r <= rsp_nxt;
  end
endmodule
`default_nettype wire
